[rtl/ped_pkg.sv]
// Shared constants, types and helper functions for the prefix edit distance block.
// Used by ped_front, ped_back and the top level prefix_edit_distance.
`default_nettype none

package ped_pkg;

    // Longest search string that is stored; later bytes of a search string are dropped.
    localparam int MAX_LEN = 32;
    localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);

    localparam int CHAR_W       = 8;
    localparam int DIST_W       = 8;
    localparam int PLEN_W       = 6;
    localparam int OUT_TDATA_W  = 16;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef enum logic
    {
        KIND_SEARCH = 1'b0,
        KIND_WORD   = 1'b1
    } kind_t;

    typedef struct packed
    {
        kind_t             kind;
        logic [CHAR_W-1:0] ch;
        logic              last;
    } item_t;

    // Increment that sticks at the largest distance.
    function automatic logic [DIST_W-1:0] sat_inc(input logic [DIST_W-1:0] d);
        logic [DIST_W-1:0] r;
        begin
            r = (d == DIST_MAX) ? DIST_MAX : d + DIST_W'(1);
            return r;
        end
    endfunction

    // Value of a column entry that has not been written since the column was cleared.
    function automatic logic [DIST_W-1:0] col_init(input logic [IDX_W-1:0] idx);
        logic [DIST_W-1:0] r;
        begin
            r = DIST_W'(idx) + DIST_W'(1);
            return r;
        end
    endfunction

endpackage

`default_nettype wire

[rtl/ped_ram.sv]
// Generic single write port, single read port RAM with a registered read.
// No dependencies.
`default_nettype none

module ped_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

[rtl/ped_front.sv]
// Front part: accepts input words, classifies them and queues them for the back part.
// Depends on ped_pkg.
`default_nettype none

module ped_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [ped_pkg::CHAR_W-1:0]  s_tdata,   // [7:0] character
    input  wire logic                        s_tuser,   // [0] command
    input  wire logic                        s_tlast,
    output logic                             item_valid,
    input  wire logic                        item_ready,
    output ped_pkg::item_t                   item
);

    ped_pkg::item_t             q_mem_reg [ped_pkg::QUEUE_DEPTH];
    logic [ped_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ped_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ped_pkg::QPTR_W:0]   count_reg, count_next;
    ped_pkg::item_t             in_item;
    logic                       push;
    logic                       pop;

    always_comb
    begin
        in_item.kind = s_tuser ? ped_pkg::KIND_WORD : ped_pkg::KIND_SEARCH;
        in_item.ch   = s_tdata;
        in_item.last = s_tlast;
    end

    assign s_tready   = (count_reg != (ped_pkg::QPTR_W + 1)'(ped_pkg::QUEUE_DEPTH));
    assign item_valid = (count_reg != '0);
    assign item       = q_mem_reg[rd_ptr_reg];
    assign push       = s_tvalid && s_tready;
    assign pop        = item_valid && item_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == ped_pkg::QPTR_W'(ped_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + ped_pkg::QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == ped_pkg::QPTR_W'(ped_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + ped_pkg::QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + (ped_pkg::QPTR_W + 1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (ped_pkg::QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

[rtl/ped_back.sv]
// Back part: stores the search string and sweeps the Levenshtein column, one cell per cycle unless the output stalls.
// Depends on ped_pkg and ped_ram; emits one result word per prefix on a word's last byte.
`default_nettype none

module ped_back (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             item_valid,
    output logic                                  item_ready,
    input  wire ped_pkg::item_t                   item,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [ped_pkg::OUT_TDATA_W-1:0]       m_tdata,
    output logic                                  m_tlast
);

    typedef enum logic [1:0]
    {
        ST_IDLE  = 2'b01,
        ST_SWEEP = 2'b10
    } state_t;

    state_t                       state_reg, state_next;
    logic [ped_pkg::LEN_W-1:0]    len_reg, len_next;
    logic                         new_search_reg, new_search_next;
    logic [ped_pkg::DIST_W-1:0]   wpos_reg, wpos_next;
    logic [ped_pkg::IDX_W-1:0]    cur_idx_reg, cur_idx_next;
    logic [ped_pkg::MAX_LEN-1:0]  col_vld_reg, col_vld_next;
    logic                         out_valid_reg, out_valid_next;

    logic [ped_pkg::DIST_W-1:0]   diag_reg, diag_next;
    logic [ped_pkg::DIST_W-1:0]   top_reg, top_next;
    logic [ped_pkg::CHAR_W-1:0]   ch_reg, ch_next;
    logic                         last_reg, last_next;
    logic                         col_vld_q_reg;
    logic [ped_pkg::PLEN_W-1:0]   out_plen_reg, out_plen_next;
    logic [ped_pkg::DIST_W-1:0]   out_dist_reg, out_dist_next;
    logic                         out_last_reg, out_last_next;

    logic [ped_pkg::IDX_W-1:0]    rd_addr;
    logic [ped_pkg::CHAR_W-1:0]   store_rdata;
    logic [ped_pkg::DIST_W-1:0]   col_rdata;
    logic                         store_we;
    logic [ped_pkg::LEN_W-1:0]    len_eff;
    logic                         out_free;
    logic                         stall;
    logic                         advance;
    logic                         finish;
    logic                         pop;
    logic [ped_pkg::LEN_W-1:0]    idx_len;
    logic [ped_pkg::DIST_W-1:0]   old_val;
    logic [ped_pkg::DIST_W-1:0]   min_val;
    logic [ped_pkg::DIST_W-1:0]   new_val;

    ped_ram #(
        .WIDTH (ped_pkg::CHAR_W),
        .DEPTH (ped_pkg::MAX_LEN)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (ped_pkg::IDX_W'(len_eff)),
        .wdata (item.ch),
        .raddr (rd_addr),
        .rdata (store_rdata)
    );

    ped_ram #(
        .WIDTH (ped_pkg::DIST_W),
        .DEPTH (ped_pkg::MAX_LEN)
    ) u_column (
        .clk   (clk),
        .we    (advance),
        .waddr (cur_idx_reg),
        .wdata (new_val),
        .raddr (rd_addr),
        .rdata (col_rdata)
    );

    assign item_ready = (state_reg == ST_IDLE);
    assign pop        = item_valid && item_ready;
    assign len_eff    = new_search_reg ? '0 : len_reg;
    assign store_we   = pop && (item.kind == ped_pkg::KIND_SEARCH)
                     && (len_eff < ped_pkg::LEN_W'(ped_pkg::MAX_LEN));

    // The sweep holds while a result is due and the output register is still full.
    assign out_free = !out_valid_reg || m_tready;
    assign stall    = (state_reg == ST_SWEEP) && last_reg && !out_free;
    assign advance  = (state_reg == ST_SWEEP) && !stall;
    assign idx_len  = ped_pkg::LEN_W'(cur_idx_reg) + ped_pkg::LEN_W'(1);
    assign finish   = advance && (idx_len == len_reg);

    // One Levenshtein cell: entries never written since the last clear read as their
    // initial value.
    always_comb
    begin
        old_val = col_vld_q_reg ? col_rdata : ped_pkg::col_init(cur_idx_reg);
        min_val = top_reg;
        if (old_val < min_val)
        begin
            min_val = old_val;
        end
        if (diag_reg < min_val)
        begin
            min_val = diag_reg;
        end
        new_val = (store_rdata == ch_reg) ? diag_reg : ped_pkg::sat_inc(min_val);
    end

    // The read address leads the cell being computed, since the memories read through a register.
    always_comb
    begin
        case (state_reg)
            ST_SWEEP:
            begin
                if (stall)
                begin
                    rd_addr = cur_idx_reg;
                end
                else if (finish)
                begin
                    rd_addr = '0;
                end
                else
                begin
                    rd_addr = cur_idx_reg + ped_pkg::IDX_W'(1);
                end
            end
            default:
            begin
                rd_addr = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        len_next        = len_reg;
        new_search_next = new_search_reg;
        wpos_next       = wpos_reg;
        cur_idx_next    = cur_idx_reg;
        col_vld_next    = col_vld_reg;
        out_valid_next  = out_valid_reg;
        diag_next       = diag_reg;
        top_next        = top_reg;
        ch_next         = ch_reg;
        last_next       = last_reg;
        out_plen_next   = out_plen_reg;
        out_dist_next   = out_dist_reg;
        out_last_next   = out_last_reg;

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (pop && (item.kind == ped_pkg::KIND_SEARCH))
                begin
                    // A search byte abandons any partial word.
                    col_vld_next    = '0;
                    wpos_next       = '0;
                    len_next        = store_we ? len_eff + ped_pkg::LEN_W'(1) : len_eff;
                    new_search_next = item.last;
                end
                else if (pop)
                begin
                    wpos_next    = ped_pkg::sat_inc(wpos_reg);
                    diag_next    = wpos_reg;
                    top_next     = ped_pkg::sat_inc(wpos_reg);
                    ch_next      = item.ch;
                    last_next    = item.last;
                    cur_idx_next = '0;
                    if (len_reg != '0)
                    begin
                        state_next = ST_SWEEP;
                    end
                    else if (item.last)
                    begin
                        // Empty search string: nothing to report, the word just ends.
                        col_vld_next = '0;
                        wpos_next    = '0;
                    end
                end
            end
            ST_SWEEP:
            begin
                if (advance)
                begin
                    col_vld_next[cur_idx_reg] = 1'b1;
                    diag_next                 = old_val;
                    top_next                  = new_val;
                    if (last_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_plen_next  = ped_pkg::PLEN_W'(idx_len);
                        out_dist_next  = new_val;
                        out_last_next  = (idx_len == len_reg);
                    end
                    if (finish)
                    begin
                        state_next   = ST_IDLE;
                        cur_idx_next = '0;
                        if (last_reg)
                        begin
                            col_vld_next = '0;
                            wpos_next    = '0;
                        end
                    end
                    else
                    begin
                        cur_idx_next = cur_idx_reg + ped_pkg::IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            len_reg        <= '0;
            new_search_reg <= 1'b1;
            wpos_reg       <= '0;
            cur_idx_reg    <= '0;
            col_vld_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            len_reg        <= len_next;
            new_search_reg <= new_search_next;
            wpos_reg       <= wpos_next;
            cur_idx_reg    <= cur_idx_next;
            col_vld_reg    <= col_vld_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        diag_reg      <= diag_next;
        top_reg       <= top_next;
        ch_reg        <= ch_next;
        last_reg      <= last_next;
        col_vld_q_reg <= col_vld_reg[rd_addr];
        out_plen_reg  <= out_plen_next;
        out_dist_reg  <= out_dist_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = ped_pkg::OUT_TDATA_W'({out_dist_reg, out_plen_reg});
    assign m_tlast  = out_last_reg;

    // A sweep only runs over a non-empty stored string.
    a_sweep_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |-> (len_reg != '0))
        else $error("sweep started with an empty search string");

    // The cell index never runs past the stored length.
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |-> (idx_len <= len_reg))
        else $error("cell index beyond search length");

    // The index is back at the first cell whenever the back part waits for an item.
    a_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (cur_idx_reg == '0))
        else $error("cell index not cleared while idle");

    // After the full-string result of a word, the column is clear for the next word.
    a_word_end: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && last_reg && finish) |=> ((state_reg == ST_IDLE) && (col_vld_reg == '0)
            && (wpos_reg == '0)))
        else $error("column not cleared after a word's last byte");

endmodule

`default_nettype wire

[rtl/prefix_edit_distance.sv]
// Top level of the prefix edit distance block: a front queue and the column sweep engine.
// Depends on ped_pkg, ped_front, ped_back and ped_ram.
//
// Use: the slave channel carries one byte per word. tuser low means a byte of the
// search string, tuser high a byte of a dictionary word; tlast marks the final byte of
// either. The first search byte after a finished search string starts a new one, and
// bytes beyond 32 are dropped while their tlast still ends the string. A search byte
// also abandons any word that is half done.
// Each word byte updates one Levenshtein column over the stored string, one cell per
// cycle unless a result waits on the receiver: the engine takes the byte, then sweeps
// the N cells, N being the search string length, and takes no new byte until the sweep
// ends (a search byte, or a word byte of an empty search string, is only taken). The
// rate is set by the single read and write port of the column memory.
// On a word's final byte the master channel delivers N result words, one per prefix
// length 1..N, in that order: prefix length, edit distance from that prefix to the whole
// word (saturated at 255), and tlast on the full-string result. The first result is
// registered after the byte moves the engine into its sweep state and the first cell is
// computed, then one per cycle while the receiver takes them. When the receiver stalls
// the sweep waits cell by cell; the two-entry input queue keeps taking bytes until it is full.
// Reset empties the search string and restores the column to its initial values;
// there is no clearing pass and the block accepts words right after reset.
`default_nettype none

module prefix_edit_distance (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [ped_pkg::CHAR_W-1:0]          s_tdata,  // [7:0] character
    input  wire logic                                s_tuser,  // [0] command
    input  wire logic                                s_tlast,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [ped_pkg::OUT_TDATA_W-1:0]          m_tdata,  // [5:0] prefix_len,
                                                               // [13:6] distance, [15:14] 0
    output logic                                     m_tlast   // last_result
);

    logic           item_valid;
    logic           item_ready;
    ped_pkg::item_t item;

    ped_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    ped_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire
